### rtl/mcsfd_pkg.sv
// Shared types and constants of the multi-channel sync-frame deframer.
package mcsfd_pkg;

  // Channel count is tied to the three identifier registers and the 2-bit channel port.
  localparam int CHANNEL_COUNT = 3;
  localparam int IDENT_W       = 11;
  localparam int CHAN_W        = 2;
  localparam int LEN_W         = 16;
  localparam int LEN_EXTRA     = 8;

  // Register indexes on the config port.
  localparam logic [CHAN_W-1:0] CFG_CH0_IDENT = 2'd0;
  localparam logic [CHAN_W-1:0] CFG_CH1_IDENT = 2'd1;
  localparam logic [CHAN_W-1:0] CFG_CH2_IDENT = 2'd2;

  localparam logic [IDENT_W-1:0] CH0_IDENT_RST = 11'h090;
  localparam logic [IDENT_W-1:0] CH1_IDENT_RST = 11'h108;
  localparam logic [IDENT_W-1:0] CH2_IDENT_RST = 11'h7F8;

  // Header 55 AA 55 AA, footer 66 CC 66 CC.
  localparam logic [7:0] SYNC_A = 8'h55;
  localparam logic [7:0] SYNC_B = 8'hAA;
  localparam logic [7:0] TAIL_A = 8'h66;
  localparam logic [7:0] TAIL_B = 8'hCC;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_COLLECT = 2'd1,
    MODE_DONE    = 2'd2
  } mode_t;

  // Sync tracker progress: number of pattern bytes matched so far.
  typedef enum logic [1:0] {
    PH_NONE  = 2'd0,
    PH_ONE   = 2'd1,
    PH_TWO   = 2'd2,
    PH_THREE = 2'd3
  } phase_t;

endpackage

### rtl/multi_channel_sync_frame_deframer.sv
// Top level of the multi-channel sync-frame deframer.
//
// Usage:
//   Input channel (in_valid / in_stall): one CAN data byte per transfer with
//   the 11-bit identifier of the CAN frame that carried it. Three identifier
//   registers, written over the cfg_ port (cfg_ready is always high), pick
//   three independent channels; the lowest matching channel wins. A byte on
//   any other identifier is consumed and gives no result.
//   Each channel hunts for a 55 AA 55 AA header, collects body bytes after it
//   and closes the frame on a 66 CC 66 CC footer. Every matched byte gives one
//   result transfer (out_valid / out_stall) reporting the capture and, on the
//   closing byte, frame_done / frame_good with message id and length.
// Throughput: one byte per cycle sustained while out_stall is low. The channel
//   logic sits between the input and output registers, so out_valid rises once
//   the byte leaves the input register; per-channel state closes its
//   read-modify-write per byte, so back-to-back bytes of one channel need no bypass.
// Reset (rst_n low, synchronous): channels go idle with all trackers, indexes,
//   lengths and ids cleared; identifiers return to 0x090, 0x108, 0x7F8.
// Stall: while out_stall holds a result, the input register keeps its byte
//   and in_stall rises only if that register is occupied.
module multi_channel_sync_frame_deframer #(
  parameter int BUFFER_BYTES = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // config write port
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mcsfd_pkg::CHAN_W-1:0]      cfg_index,
  input  logic [mcsfd_pkg::IDENT_W-1:0]     cfg_data,
  // byte input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mcsfd_pkg::IDENT_W-1:0]     in_can_ident,
  input  logic [7:0]                        in_data_byte,
  // result output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mcsfd_pkg::CHAN_W-1:0]      out_channel,
  output logic                              out_stored,
  output logic [7:0]                        out_store_index,
  output logic [7:0]                        out_stored_byte,
  output logic                              out_frame_done,
  output logic                              out_frame_good,
  output logic [mcsfd_pkg::LEN_W-1:0]       out_message_id,
  output logic [mcsfd_pkg::LEN_W-1:0]       out_payload_length
);

  // Body index runs 0..BUFFER_BYTES; compares against length+8 need 17 bits.
  localparam int IW = $clog2(BUFFER_BYTES + 1);
  localparam int CW = mcsfd_pkg::LEN_W + 1;
  localparam logic [IW-1:0] IDX_LIMIT = IW'(BUFFER_BYTES);
  localparam int NCH = mcsfd_pkg::CHANNEL_COUNT;

  // identifier registers
  logic [mcsfd_pkg::IDENT_W-1:0] ident_r [NCH];

  // per-channel state
  mcsfd_pkg::phase_t             hphase_r [NCH];
  mcsfd_pkg::phase_t             fphase_r [NCH];
  mcsfd_pkg::mode_t              mode_r   [NCH];
  logic [IW-1:0]                 idx_r    [NCH];
  logic [mcsfd_pkg::LEN_W-1:0]   len_r    [NCH];
  logic [mcsfd_pkg::LEN_W-1:0]   mid_r    [NCH];
  logic [7:0]                    lenlo_r  [NCH];

  // input register
  logic                          s1_valid_r;
  logic [mcsfd_pkg::IDENT_W-1:0] s1_ident_r;
  logic [7:0]                    s1_byte_r;

  // output register
  logic                          out_valid_r;
  logic [mcsfd_pkg::CHAN_W-1:0]  out_channel_r;
  logic                          out_stored_r;
  logic [7:0]                    out_store_index_r;
  logic [7:0]                    out_stored_byte_r;
  logic                          out_frame_done_r;
  logic                          out_frame_good_r;
  logic [mcsfd_pkg::LEN_W-1:0]   out_message_id_r;
  logic [mcsfd_pkg::LEN_W-1:0]   out_payload_length_r;

  // datapath
  logic                          proc;
  logic                          in_accept;
  logic                          hit;
  logic [mcsfd_pkg::CHAN_W-1:0]  sel;
  mcsfd_pkg::phase_t             hphase_nxt;
  mcsfd_pkg::phase_t             fphase_nxt;
  mcsfd_pkg::mode_t              mode_nxt;
  logic [IW-1:0]                 idx_nxt;
  logic [mcsfd_pkg::LEN_W-1:0]   len_nxt;
  logic [mcsfd_pkg::LEN_W-1:0]   mid_nxt;
  logic [7:0]                    lenlo_nxt;
  logic                          stored_nxt;
  logic [7:0]                    sidx_nxt;
  logic [7:0]                    sbyte_nxt;
  logic                          done_nxt;
  logic                          good_nxt;
  logic [CW-1:0]                 len_lim;

  // Byte in the input register moves on whenever the output slot is free.
  assign proc      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !proc;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Channel match, lowest index wins.
  always_comb begin
    hit = 1'b0;
    sel = '0;
    for (int i = NCH - 1; i >= 0; i--) begin
      if (ident_r[i] == s1_ident_r) begin
        hit = 1'b1;
        sel = mcsfd_pkg::CHAN_W'(i);
      end
    end
  end

  // One byte through the selected channel: capture, header, footer, report.
  always_comb begin
    hphase_nxt = hphase_r[sel];
    fphase_nxt = fphase_r[sel];
    mode_nxt   = mode_r[sel];
    idx_nxt    = idx_r[sel];
    len_nxt    = len_r[sel];
    mid_nxt    = mid_r[sel];
    lenlo_nxt  = lenlo_r[sel];
    stored_nxt = 1'b0;
    sidx_nxt   = '0;
    sbyte_nxt  = '0;
    done_nxt   = 1'b0;
    good_nxt   = 1'b0;
    len_lim    = '0;

    // body capture
    if (mode_nxt == mcsfd_pkg::MODE_COLLECT) begin
      stored_nxt = 1'b1;
      sidx_nxt   = 8'(idx_nxt);
      sbyte_nxt  = s1_byte_r;
      if (idx_nxt == IW'(0)) begin
        mid_nxt[7:0] = s1_byte_r;
      end else if (idx_nxt == IW'(1)) begin
        mid_nxt[15:8] = s1_byte_r;
      end else if (idx_nxt == IW'(2)) begin
        lenlo_nxt = s1_byte_r;
      end else if (idx_nxt == IW'(3)) begin
        len_nxt = {s1_byte_r, lenlo_nxt};
      end
      idx_nxt = idx_nxt + IW'(1);
      len_lim = {1'b0, len_nxt} + CW'(mcsfd_pkg::LEN_EXTRA);
      if ((CW'(idx_nxt) > len_lim) || (idx_nxt >= IDX_LIMIT)) begin
        mode_nxt = mcsfd_pkg::MODE_IDLE;
      end
    end

    // header tracker; completion restarts collection
    if (s1_byte_r == mcsfd_pkg::SYNC_A) begin
      case (hphase_nxt)
        mcsfd_pkg::PH_NONE: hphase_nxt = mcsfd_pkg::PH_ONE;
        mcsfd_pkg::PH_TWO:  hphase_nxt = mcsfd_pkg::PH_THREE;
        default:            hphase_nxt = mcsfd_pkg::PH_NONE;
      endcase
    end else if (s1_byte_r == mcsfd_pkg::SYNC_B) begin
      case (hphase_nxt)
        mcsfd_pkg::PH_ONE: hphase_nxt = mcsfd_pkg::PH_TWO;
        mcsfd_pkg::PH_THREE: begin
          hphase_nxt = mcsfd_pkg::PH_NONE;
          mode_nxt   = mcsfd_pkg::MODE_COLLECT;
          idx_nxt    = '0;
        end
        default: hphase_nxt = mcsfd_pkg::PH_NONE;
      endcase
    end else begin
      hphase_nxt = mcsfd_pkg::PH_NONE;
    end

    // footer tracker; completion closes a frame under collection
    if (s1_byte_r == mcsfd_pkg::TAIL_A) begin
      case (fphase_nxt)
        mcsfd_pkg::PH_NONE: fphase_nxt = mcsfd_pkg::PH_ONE;
        mcsfd_pkg::PH_TWO:  fphase_nxt = mcsfd_pkg::PH_THREE;
        default:            fphase_nxt = mcsfd_pkg::PH_NONE;
      endcase
    end else if (s1_byte_r == mcsfd_pkg::TAIL_B) begin
      case (fphase_nxt)
        mcsfd_pkg::PH_ONE: fphase_nxt = mcsfd_pkg::PH_TWO;
        mcsfd_pkg::PH_THREE: begin
          fphase_nxt = mcsfd_pkg::PH_NONE;
          if (mode_nxt != mcsfd_pkg::MODE_IDLE) begin
            mode_nxt = mcsfd_pkg::MODE_DONE;
          end
        end
        default: fphase_nxt = mcsfd_pkg::PH_NONE;
      endcase
    end else begin
      fphase_nxt = mcsfd_pkg::PH_NONE;
    end

    // frame report
    if (mode_nxt == mcsfd_pkg::MODE_DONE) begin
      done_nxt = 1'b1;
      good_nxt = (CW'(idx_nxt) == ({1'b0, len_nxt} + CW'(mcsfd_pkg::LEN_EXTRA)));
      mode_nxt = mcsfd_pkg::MODE_IDLE;
    end
  end

  // identifier registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ident_r[0] <= mcsfd_pkg::CH0_IDENT_RST;
      ident_r[1] <= mcsfd_pkg::CH1_IDENT_RST;
      ident_r[2] <= mcsfd_pkg::CH2_IDENT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mcsfd_pkg::CFG_CH0_IDENT: ident_r[0] <= cfg_data;
        mcsfd_pkg::CFG_CH1_IDENT: ident_r[1] <= cfg_data;
        mcsfd_pkg::CFG_CH2_IDENT: ident_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-channel state write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCH; i++) begin
        hphase_r[i] <= mcsfd_pkg::PH_NONE;
        fphase_r[i] <= mcsfd_pkg::PH_NONE;
        mode_r[i]   <= mcsfd_pkg::MODE_IDLE;
        idx_r[i]    <= '0;
        len_r[i]    <= '0;
        mid_r[i]    <= '0;
        lenlo_r[i]  <= '0;
      end
    end else if (proc && hit) begin
      hphase_r[sel] <= hphase_nxt;
      fphase_r[sel] <= fphase_nxt;
      mode_r[sel]   <= mode_nxt;
      idx_r[sel]    <= idx_nxt;
      len_r[sel]    <= len_nxt;
      mid_r[sel]    <= mid_nxt;
      lenlo_r[sel]  <= lenlo_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_valid_r || proc) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_ident_r <= in_can_ident;
      s1_byte_r  <= in_data_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc) begin
      out_valid_r <= hit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && hit) begin
      out_channel_r        <= sel;
      out_stored_r         <= stored_nxt;
      out_store_index_r    <= sidx_nxt;
      out_stored_byte_r    <= sbyte_nxt;
      out_frame_done_r     <= done_nxt;
      out_frame_good_r     <= good_nxt;
      out_message_id_r     <= done_nxt ? mid_nxt : '0;
      out_payload_length_r <= done_nxt ? len_nxt : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_channel        = out_channel_r;
  assign out_stored         = out_stored_r;
  assign out_store_index    = out_store_index_r;
  assign out_stored_byte    = out_stored_byte_r;
  assign out_frame_done     = out_frame_done_r;
  assign out_frame_good     = out_frame_good_r;
  assign out_message_id     = out_message_id_r;
  assign out_payload_length = out_payload_length_r;

  // ---------------------------------------------------------------------
  // assertions

  // the done mode never survives into stored state
  a_no_stored_done: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r[0] != mcsfd_pkg::MODE_DONE) && (mode_r[1] != mcsfd_pkg::MODE_DONE) &&
    (mode_r[2] != mcsfd_pkg::MODE_DONE))
    else $error("channel mode stuck in done");

  // a closed frame leaves its channel idle
  a_done_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && hit && done_nxt) |=> (mode_r[$past(sel)] == mcsfd_pkg::MODE_IDLE))
    else $error("channel still collecting after frame done");

  // body index bounded by buffer size
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r[0] <= IDX_LIMIT) && (idx_r[1] <= IDX_LIMIT) && (idx_r[2] <= IDX_LIMIT))
    else $error("body index beyond buffer");

  // input stalls only while the input register is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a held result");

  // results only name existing channels
  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_channel_r < mcsfd_pkg::CHAN_W'(NCH)))
    else $error("result on a nonexistent channel");

endmodule

### verif/deframe_checker.sv
// Checker: watches all three channels of the deframer, predicts each result and compares it.
module deframe_checker #(
  parameter int BUFFER_BYTES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [mcsfd_pkg::CHAN_W-1:0]  cfg_index,
  input  logic [mcsfd_pkg::IDENT_W-1:0] cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [mcsfd_pkg::IDENT_W-1:0] in_can_ident,
  input  logic [7:0]                    in_data_byte,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [mcsfd_pkg::CHAN_W-1:0]  out_channel,
  input  logic                          out_stored,
  input  logic [7:0]                    out_store_index,
  input  logic [7:0]                    out_stored_byte,
  input  logic                          out_frame_done,
  input  logic                          out_frame_good,
  input  logic [mcsfd_pkg::LEN_W-1:0]   out_message_id,
  input  logic [mcsfd_pkg::LEN_W-1:0]   out_payload_length,
  output int                            mismatch_count,
  output int                            results_owed,
  output int                            results_checked,
  output int                            frames_closed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W = $clog2(BUFFER_BYTES) + 1;
  localparam int NCH   = mcsfd_pkg::CHANNEL_COUNT;

  typedef struct packed {
    logic [mcsfd_pkg::CHAN_W-1:0] channel;
    logic                         stored;
    logic [7:0]                   store_index;
    logic [7:0]                   stored_byte;
    logic                         frame_done;
    logic                         frame_good;
    logic [mcsfd_pkg::LEN_W-1:0]  message_id;
    logic [mcsfd_pkg::LEN_W-1:0]  payload_length;
  } deframe_result_t;

  logic [mcsfd_pkg::IDENT_W-1:0] ident_reg [NCH];
  mcsfd_pkg::phase_t             hdr_phase [NCH];
  mcsfd_pkg::phase_t             ftr_phase [NCH];
  mcsfd_pkg::mode_t              mode      [NCH];
  logic [IDX_W-1:0]              body_idx  [NCH];
  logic [mcsfd_pkg::LEN_W-1:0]   decl_len  [NCH];
  logic [mcsfd_pkg::LEN_W-1:0]   msg_id    [NCH];
  logic [7:0]                    len_lo    [NCH];

  deframe_result_t owed_q [$];
  int fails;
  int checked;
  int closed;

  // One byte through the channel it maps to; returns 0 when no channel matches.
  function automatic bit deframe_step(input logic [mcsfd_pkg::IDENT_W-1:0] ident,
                                      input logic [7:0] b, output deframe_result_t r);
    int ch;
    ch = -1;
    r = '0;
    for (int i = NCH - 1; i >= 0; i--)
      if (ident_reg[i] == ident) ch = i;
    if (ch < 0) return 1'b0;
    r.channel = mcsfd_pkg::CHAN_W'(ch);

    // capture first, trackers after
    if (mode[ch] == mcsfd_pkg::MODE_COLLECT) begin
      r.stored      = 1'b1;
      r.store_index = body_idx[ch][7:0];
      r.stored_byte = b;
      case (int'(body_idx[ch]))
        0: msg_id[ch][7:0] = b;
        1: msg_id[ch][15:8] = b;
        2: len_lo[ch] = b;
        3: decl_len[ch] = {b, len_lo[ch]};
        default: ;
      endcase
      body_idx[ch] = body_idx[ch] + 1'b1;
      if (int'(body_idx[ch]) > int'(decl_len[ch]) + mcsfd_pkg::LEN_EXTRA ||
          int'(body_idx[ch]) >= BUFFER_BYTES)
        mode[ch] = mcsfd_pkg::MODE_IDLE;
    end

    case (b)
      mcsfd_pkg::SYNC_A:
        hdr_phase[ch] = (hdr_phase[ch] == mcsfd_pkg::PH_NONE) ? mcsfd_pkg::PH_ONE :
                        (hdr_phase[ch] == mcsfd_pkg::PH_TWO) ? mcsfd_pkg::PH_THREE :
                        mcsfd_pkg::PH_NONE;
      mcsfd_pkg::SYNC_B: begin
        if (hdr_phase[ch] == mcsfd_pkg::PH_ONE) hdr_phase[ch] = mcsfd_pkg::PH_TWO;
        else if (hdr_phase[ch] == mcsfd_pkg::PH_THREE) begin
          hdr_phase[ch] = mcsfd_pkg::PH_NONE;
          mode[ch]      = mcsfd_pkg::MODE_COLLECT;
          body_idx[ch]  = '0;
        end else hdr_phase[ch] = mcsfd_pkg::PH_NONE;
      end
      default: hdr_phase[ch] = mcsfd_pkg::PH_NONE;
    endcase

    case (b)
      mcsfd_pkg::TAIL_A:
        ftr_phase[ch] = (ftr_phase[ch] == mcsfd_pkg::PH_NONE) ? mcsfd_pkg::PH_ONE :
                        (ftr_phase[ch] == mcsfd_pkg::PH_TWO) ? mcsfd_pkg::PH_THREE :
                        mcsfd_pkg::PH_NONE;
      mcsfd_pkg::TAIL_B: begin
        if (ftr_phase[ch] == mcsfd_pkg::PH_ONE) ftr_phase[ch] = mcsfd_pkg::PH_TWO;
        else if (ftr_phase[ch] == mcsfd_pkg::PH_THREE) begin
          ftr_phase[ch] = mcsfd_pkg::PH_NONE;
          if (mode[ch] != mcsfd_pkg::MODE_IDLE) mode[ch] = mcsfd_pkg::MODE_DONE;
        end else ftr_phase[ch] = mcsfd_pkg::PH_NONE;
      end
      default: ftr_phase[ch] = mcsfd_pkg::PH_NONE;
    endcase

    if (mode[ch] == mcsfd_pkg::MODE_DONE) begin
      r.frame_done     = 1'b1;
      r.frame_good     = (int'(body_idx[ch]) == int'(decl_len[ch]) + mcsfd_pkg::LEN_EXTRA);
      r.message_id     = msg_id[ch];
      r.payload_length = decl_len[ch];
      mode[ch]         = mcsfd_pkg::MODE_IDLE;
    end
    return 1'b1;
  endfunction

  function automatic string show(input deframe_result_t r);
    return $sformatf("ch=%0d stored=%0d idx=%0d byte=%02h done=%0d good=%0d id=%04h len=%04h",
                     r.channel, r.stored, r.store_index, r.stored_byte, r.frame_done,
                     r.frame_good, r.message_id, r.payload_length);
  endfunction

  function automatic string diff_fields(input deframe_result_t e, input deframe_result_t a);
    string s;
    s = "";
    if (e.channel !== a.channel)               s = {s, " channel"};
    if (e.stored !== a.stored)                 s = {s, " stored"};
    if (e.store_index !== a.store_index)       s = {s, " store_index"};
    if (e.stored_byte !== a.stored_byte)       s = {s, " stored_byte"};
    if (e.frame_done !== a.frame_done)         s = {s, " frame_done"};
    if (e.frame_good !== a.frame_good)         s = {s, " frame_good"};
    if (e.message_id !== a.message_id)         s = {s, " message_id"};
    if (e.payload_length !== a.payload_length) s = {s, " payload_length"};
    return s;
  endfunction

  always @(posedge clk) begin
    deframe_result_t seen;
    deframe_result_t want;
    string diff;
    if (!rst_n) begin
      ident_reg[0] = mcsfd_pkg::CH0_IDENT_RST;
      ident_reg[1] = mcsfd_pkg::CH1_IDENT_RST;
      ident_reg[2] = mcsfd_pkg::CH2_IDENT_RST;
      for (int c = 0; c < NCH; c++) begin
        hdr_phase[c] = mcsfd_pkg::PH_NONE;
        ftr_phase[c] = mcsfd_pkg::PH_NONE;
        mode[c]      = mcsfd_pkg::MODE_IDLE;
        body_idx[c]  = '0;
        decl_len[c]  = '0;
        msg_id[c]    = '0;
        len_lo[c]    = '0;
      end
      owed_q.delete();
      fails   = 0;
      checked = 0;
      closed  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mcsfd_pkg::CFG_CH0_IDENT: ident_reg[0] = cfg_data;
          mcsfd_pkg::CFG_CH1_IDENT: ident_reg[1] = cfg_data;
          mcsfd_pkg::CFG_CH2_IDENT: ident_reg[2] = cfg_data;
          default: ;
        endcase
      end
      // compare before predicting: a result never comes from this edge's byte
      if (out_valid && !out_stall) begin
        seen = {out_channel, out_stored, out_store_index, out_stored_byte, out_frame_done,
                out_frame_good, out_message_id, out_payload_length};
        if (owed_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t ns: result with nothing pending: %s", $realtime, show(seen));
        end else begin
          want = owed_q.pop_front();
          checked++;
          diff = diff_fields(want, seen);
          if (diff != "") begin
            fails++;
            if (fails <= 10)
              $display("%0t ns: bad field(s)%s\n  expected %s\n  actual   %s",
                       $realtime, diff, show(want), show(seen));
          end
        end
      end
      if (in_valid && !in_stall && deframe_step(in_can_ident, in_data_byte, want)) begin
        owed_q.push_back(want);
        if (want.frame_done) closed++;
      end
    end
    mismatch_count  <= fails;
    results_owed    <= owed_q.size();
    results_checked <= checked;
    frames_closed   <= closed;
  end

endmodule

### verif/tb.sv
// Testbench top: clock, reset, byte and identifier stimulus, and the pass/fail verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 12;
  localparam int PHASE_ITEMS = 400;     // four identifier maps, ~1750 bytes with strays
  localparam int CALM_ITEMS  = 150;     // tail of the run with no gaps and no stalls
  localparam int CYCLE_LIMIT = 400000;
  localparam int STREAM_MAX  = 512;
  localparam int NCH         = mcsfd_pkg::CHANNEL_COUNT;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [mcsfd_pkg::CHAN_W-1:0]    cfg_index = '0;
  logic [mcsfd_pkg::IDENT_W-1:0]   cfg_data  = '0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  logic [mcsfd_pkg::IDENT_W-1:0]   in_can_ident = '0;
  logic [7:0]                      in_data_byte = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [mcsfd_pkg::CHAN_W-1:0]    out_channel;
  logic                            out_stored;
  logic [7:0]                      out_store_index;
  logic [7:0]                      out_stored_byte;
  logic                            out_frame_done;
  logic                            out_frame_good;
  logic [mcsfd_pkg::LEN_W-1:0]     out_message_id;
  logic [mcsfd_pkg::LEN_W-1:0]     out_payload_length;

  int mismatch_count;
  int results_owed;
  int results_checked;
  int frames_closed;

  // Knobs shared by the driver and the stall generator.
  bit calm      = 1'b0;
  int gap_pct   = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int cycle_count = 0;

  // Identifiers currently programmed, so channel traffic can target them.
  logic [mcsfd_pkg::IDENT_W-1:0] ident_cfg [NCH];

  // Per-channel byte streams: each holds one framed message, fed out byte by byte
  // and interleaved with the other channels.
  logic [7:0] stream_buf [NCH][STREAM_MAX];
  int         stream_len [NCH];
  int         stream_pos [NCH];

  int chan_bytes  = 0;
  int stray_bytes = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  multi_channel_sync_frame_deframer dut (.*);
  deframe_checker                   chk (.*);

  // Hard stop: far beyond the slowest legal run (max gaps + max stalls on every byte).
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result-side back-pressure: random stall bursts; held off entirely when calm.
  always @(posedge clk) begin
    if (calm || stall_pct == 0) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 9);
    end
  end

  function automatic int pick_pct();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 15;
      default: return 40;
    endcase
  endfunction

  // One byte transfer. An optional idle burst comes first; valid stays high
  // across back-to-back transfers so it is never dropped and raised in one step.
  task automatic send_byte(input logic [mcsfd_pkg::IDENT_W-1:0] id, input logic [7:0] b);
    int gap;
    if (!calm && $urandom_range(99) < gap_pct) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_can_ident <= id;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_word(input logic [mcsfd_pkg::IDENT_W-1:0] id, input logic [31:0] w);
    for (int k = 3; k >= 0; k--) send_byte(id, w[8*k +: 8]);
  endtask

  // Drain: stop traffic, let the last transfer reach the checker, wait out every
  // pending result, then allow the pipeline latency for bytes that give no result.
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Program all three identifier registers in one burst (block must be idle).
  task automatic write_idents(input logic [mcsfd_pkg::IDENT_W-1:0] id0,
                              input logic [mcsfd_pkg::IDENT_W-1:0] id1,
                              input logic [mcsfd_pkg::IDENT_W-1:0] id2);
    logic [mcsfd_pkg::CHAN_W-1:0]  which [NCH] = '{mcsfd_pkg::CFG_CH0_IDENT,
                                                   mcsfd_pkg::CFG_CH1_IDENT,
                                                   mcsfd_pkg::CFG_CH2_IDENT};
    logic [mcsfd_pkg::IDENT_W-1:0] vals  [NCH];
    vals = '{id0, id1, id2};
    cfg_valid <= 1'b1;
    for (int r = 0; r < NCH; r++) begin
      cfg_index    <= which[r];
      cfg_data     <= vals[r];
      ident_cfg[r] = vals[r];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic void put(input int ch, input logic [7:0] b);
    stream_buf[ch][stream_len[ch]] = b;
    stream_len[ch] = stream_len[ch] + 1;
  endfunction

  // Build one message for a channel. Mostly well formed (header, id, length,
  // exactly length payload bytes, footer) so frames close good; the rest bend it:
  // off-by-a-few payload, oversized length that hits the buffer limit, huge
  // declared length, broken header, missing or broken footer.
  task automatic build_frame(input int ch);
    int kind;
    int len;
    int pay;
    logic [15:0] mid;
    kind = $urandom_range(199);
    mid  = 16'($urandom);
    if (kind < 3)       len = $urandom_range(240, 300);
    else if (kind < 10) len = $urandom_range(13, 65535);
    else                len = $urandom_range(0, 12);
    pay = (len > 300) ? int'($urandom_range(0, 12)) : len;
    if (kind >= 10 && kind < 40) begin
      pay = pay - 2 + int'($urandom_range(0, 4));
      if (pay < 0) pay = 0;
    end
    stream_len[ch] = 0;
    stream_pos[ch] = 0;
    put(ch, mcsfd_pkg::SYNC_A);
    put(ch, mcsfd_pkg::SYNC_B);
    put(ch, mcsfd_pkg::SYNC_A);
    if (kind >= 40 && kind < 55) put(ch, 8'($urandom_range(0, 255)));
    else                         put(ch, mcsfd_pkg::SYNC_B);
    put(ch, mid[7:0]);
    put(ch, mid[15:8]);
    put(ch, 8'(len));
    put(ch, 8'(len >> 8));
    for (int k = 0; k < pay; k++) put(ch, 8'($urandom_range(0, 255)));
    if (kind < 55 || kind >= 65) begin
      put(ch, mcsfd_pkg::TAIL_A);
      put(ch, mcsfd_pkg::TAIL_B);
      put(ch, mcsfd_pkg::TAIL_A);
      if (kind >= 65 && kind < 75) put(ch, 8'($urandom_range(0, 255)));
      else                         put(ch, mcsfd_pkg::TAIL_B);
    end
  endtask

  // Interleaved traffic across the channels, with a sprinkle of stray bytes on
  // arbitrary identifiers. Idle rates are re-rolled every hundred channel bytes so there
  // are stretches with heavy gaps and stretches with none.
  task automatic run_traffic(input int count, input bit last_phase);
    int ch;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        gap_pct   = pick_pct();
        stall_pct = pick_pct();
      end
      if (last_phase && n >= count - CALM_ITEMS) calm = 1'b1;
      while ($urandom_range(99) < 8) begin
        send_byte(11'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)));
        stray_bytes++;
      end
      ch = $urandom_range(0, NCH - 1);
      if (stream_pos[ch] >= stream_len[ch]) build_frame(ch);
      send_byte(ident_cfg[ch], stream_buf[ch][stream_pos[ch]]);
      stream_pos[ch] = stream_pos[ch] + 1;
      chan_bytes++;
    end
  endtask

  initial begin
    logic [mcsfd_pkg::IDENT_W-1:0] dup;
    ident_cfg = '{mcsfd_pkg::CH0_IDENT_RST, mcsfd_pkg::CH1_IDENT_RST,
                  mcsfd_pkg::CH2_IDENT_RST};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset identifiers. Stray bytes at both identifier and byte extremes.
    send_byte(11'h000, 8'h00);
    send_byte(11'h7FF, 8'hFF);
    // Channel 0: minimal good frame, id 0x1234, length 0.
    send_word(mcsfd_pkg::CH0_IDENT_RST,
              {mcsfd_pkg::SYNC_A, mcsfd_pkg::SYNC_B, mcsfd_pkg::SYNC_A, mcsfd_pkg::SYNC_B});
    send_word(mcsfd_pkg::CH0_IDENT_RST, 32'h3412_0000);
    send_word(mcsfd_pkg::CH0_IDENT_RST,
              {mcsfd_pkg::TAIL_A, mcsfd_pkg::TAIL_B, mcsfd_pkg::TAIL_A, mcsfd_pkg::TAIL_B});
    // Channel 1: footer while idle, nothing to close.
    send_word(mcsfd_pkg::CH1_IDENT_RST,
              {mcsfd_pkg::TAIL_A, mcsfd_pkg::TAIL_B, mcsfd_pkg::TAIL_A, mcsfd_pkg::TAIL_B});
    // Channel 2: header broken on its last byte.
    send_word(mcsfd_pkg::CH2_IDENT_RST,
              {mcsfd_pkg::SYNC_A, mcsfd_pkg::SYNC_B, mcsfd_pkg::SYNC_A, 8'h00});
    stray_bytes += 2;
    chan_bytes  += 20;

    // Reset identifier map.
    run_traffic(PHASE_ITEMS, 1'b0);

    // Identifier extremes.
    settle();
    write_idents(11'h000, 11'h7FF, 11'($urandom_range(0, 2047)));
    run_traffic(PHASE_ITEMS, 1'b0);

    // Duplicate identifiers: channel 0 shadows channel 1.
    settle();
    dup = 11'($urandom_range(0, 2047));
    write_idents(dup, dup, 11'($urandom_range(0, 2047)));
    run_traffic(PHASE_ITEMS, 1'b0);

    // Random map, ending with a calm stretch.
    settle();
    write_idents(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
                 11'($urandom_range(0, 2047)));
    run_traffic(PHASE_ITEMS, 1'b1);

    settle();
    $display("Sent %0d channel bytes and %0d stray bytes over four identifier maps",
             chan_bytes, stray_bytes);
    $display("Compared %0d results; %0d frames closed by a footer",
             results_checked, frames_closed);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
